>>> rtl/rgr_pkg.sv
`default_nettype none
package rgr_pkg;

    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = 8;
    localparam int REL_W     = 8;
    localparam int CNT_W     = 9;
    localparam int EDGE_AW   = 10;
    localparam int TOTAL_W   = 11;
    localparam int KEY_W     = REL_W + 2 * NODE_W;

    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_REBUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    typedef enum logic [2:0] {
        RES_ZERO   = 3'd0,
        RES_REJECT = 3'd1,
        RES_NEW    = 3'd2,
        RES_DUP    = 3'd3,
        RES_ONE    = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     scan_init;
        logic     scan_run;
        logic     scan_push;
        logic     q_init;
        logic     pop;
        logic     node_load;
        logic     add_write;
        logic     set_ready;
        logic     res_en;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       add_bad;
        logic       q_ok;
        logic       same;
        logic       add_hit;
        logic       goal_hit;
        logic       scan_end;
        logic       queue_empty;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/rgr_ctrl.sv
`default_nettype none
module rgr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rgr_pkg::stat_t stat,
    output rgr_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_ASCAN  = 6'b000100,
        S_QPOP   = 6'b001000,
        S_QNODE  = 6'b010000,
        S_QSCAN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = rgr_pkg::RES_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                case (stat.mode)
                    rgr_pkg::MODE_ADD:
                    begin
                        if (stat.add_bad)
                        begin
                            cmd.res_en  = 1'b1;
                            cmd.res_sel = rgr_pkg::RES_REJECT;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_ASCAN;
                        end
                    end
                    rgr_pkg::MODE_REBUILD:
                    begin
                        cmd.set_ready = 1'b1;
                        cmd.res_en    = 1'b1;
                    end
                    rgr_pkg::MODE_QUERY:
                    begin
                        if (!stat.q_ok)
                            cmd.res_en = 1'b1;
                        else if (stat.same)
                        begin
                            cmd.res_en  = 1'b1;
                            cmd.res_sel = rgr_pkg::RES_ONE;
                        end
                        else
                        begin
                            cmd.q_init = 1'b1;
                            state_next = S_QPOP;
                        end
                    end
                    default:
                        cmd.res_en = 1'b1;
                endcase
            end
            S_ASCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.add_hit)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = rgr_pkg::RES_DUP;
                    state_next  = S_IDLE;
                end
                else if (stat.scan_end)
                begin
                    cmd.add_write = 1'b1;
                    cmd.res_en    = 1'b1;
                    cmd.res_sel   = rgr_pkg::RES_NEW;
                    state_next    = S_IDLE;
                end
            end
            S_QPOP:
            begin
                if (stat.queue_empty)
                begin
                    cmd.res_en = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_QNODE;
                end
            end
            S_QNODE:
            begin
                cmd.node_load = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = S_QSCAN;
            end
            S_QSCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_push = 1'b1;
                if (stat.goal_hit)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = rgr_pkg::RES_ONE;
                    state_next  = S_IDLE;
                end
                else if (stat.scan_end)
                    state_next = S_QPOP;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rgr_dp.sv
`default_nettype none
module rgr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [rgr_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic [1:0]                    mode,
    input  wire logic [rgr_pkg::NODE_W-1:0]    source_node,
    input  wire logic [rgr_pkg::NODE_W-1:0]    target_node,
    input  wire logic [rgr_pkg::REL_W-1:0]     relation_kind,
    input  wire rgr_pkg::cmd_t                 cmd,
    output rgr_pkg::stat_t                     stat,
    output logic                               done,
    output logic                               status,
    output logic [rgr_pkg::EDGE_AW-1:0]        edge_index,
    output logic                               reachable
);

    logic [rgr_pkg::CNT_W-1:0]   nodes_reg;
    logic [1:0]                  mode_reg;
    logic [rgr_pkg::NODE_W-1:0]  src_reg, dst_reg, node_reg;
    logic [rgr_pkg::REL_W-1:0]   rel_reg;
    logic [rgr_pkg::TOTAL_W-1:0] total_reg;
    logic                        ready_reg;

    logic [rgr_pkg::KEY_W-1:0]   edge_mem [rgr_pkg::MAX_EDGES];
    logic [rgr_pkg::KEY_W-1:0]   edge_q_reg;
    logic [rgr_pkg::TOTAL_W-1:0] idx_reg;
    logic                        pipe_v_reg;
    logic [rgr_pkg::EDGE_AW-1:0] pipe_idx_reg;

    logic [rgr_pkg::NODE_W-1:0]  queue_mem [rgr_pkg::MAX_NODES];
    logic [rgr_pkg::NODE_W-1:0]  queue_q_reg;
    logic [rgr_pkg::CNT_W-1:0]   head_reg, tail_reg;
    logic [rgr_pkg::MAX_NODES-1:0] visited_reg;

    logic                        done_reg, status_reg, reach_reg;
    logic [rgr_pkg::EDGE_AW-1:0] index_reg;

    logic [rgr_pkg::CNT_W-1:0]   count;
    logic [rgr_pkg::KEY_W-1:0]   key;
    logic                        issue;
    logic [rgr_pkg::NODE_W-1:0]  e_src, e_dst;
    logic [rgr_pkg::REL_W-1:0]   e_rel;
    logic                        edge_hit, goal_hit, push;

    assign count = (nodes_reg > rgr_pkg::CNT_W'(rgr_pkg::MAX_NODES))
                 ? rgr_pkg::CNT_W'(rgr_pkg::MAX_NODES) : nodes_reg;
    assign key   = {rel_reg, dst_reg, src_reg};
    assign issue = cmd.scan_run && (idx_reg < total_reg);

    assign e_src = edge_q_reg[rgr_pkg::NODE_W-1:0];
    assign e_dst = edge_q_reg[2*rgr_pkg::NODE_W-1:rgr_pkg::NODE_W];
    assign e_rel = edge_q_reg[rgr_pkg::KEY_W-1:2*rgr_pkg::NODE_W];

    assign edge_hit = pipe_v_reg && (e_src == node_reg) && (e_rel == rel_reg)
                    && ({1'b0, e_dst} < count);
    assign goal_hit = edge_hit && (e_dst == dst_reg);
    assign push     = cmd.scan_run && cmd.scan_push && edge_hit && !goal_hit
                    && !visited_reg[e_dst]
                    && (tail_reg != rgr_pkg::CNT_W'(rgr_pkg::MAX_NODES));

    always_comb
    begin
        stat.mode        = mode_reg;
        stat.add_bad     = ({1'b0, src_reg} >= count) || ({1'b0, dst_reg} >= count)
                         || (rel_reg == '0)
                         || (total_reg >= rgr_pkg::TOTAL_W'(rgr_pkg::MAX_EDGES));
        stat.q_ok        = ({1'b0, src_reg} < count) && ({1'b0, dst_reg} < count)
                         && (rel_reg != '0) && ready_reg;
        stat.same        = (src_reg == dst_reg);
        stat.add_hit     = pipe_v_reg && (edge_q_reg == key);
        stat.goal_hit    = goal_hit;
        stat.scan_end    = !pipe_v_reg && (idx_reg >= total_reg);
        stat.queue_empty = (head_reg == tail_reg);
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
            edge_mem[total_reg[rgr_pkg::EDGE_AW-1:0]] <= key;
        edge_q_reg <= edge_mem[idx_reg[rgr_pkg::EDGE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_init)
            queue_mem[rgr_pkg::NODE_W'(0)] <= src_reg;
        else if (push)
            queue_mem[tail_reg[rgr_pkg::NODE_W-1:0]] <= e_dst;
        queue_q_reg <= queue_mem[head_reg[rgr_pkg::NODE_W-1:0]];
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            src_reg  <= source_node;
            dst_reg  <= target_node;
            rel_reg  <= relation_kind;
        end
        if (cmd.node_load)
            node_reg <= queue_q_reg;
        if (cmd.scan_run)
            pipe_idx_reg <= idx_reg[rgr_pkg::EDGE_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg   <= '0;
            total_reg   <= '0;
            ready_reg   <= 1'b0;
            idx_reg     <= '0;
            pipe_v_reg  <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            done_reg    <= 1'b0;
            status_reg  <= 1'b0;
            reach_reg   <= 1'b0;
            index_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
                nodes_reg <= cfg_data;
            if (cmd.add_write)
            begin
                total_reg <= total_reg + 1'b1;
                ready_reg <= 1'b0;
            end
            else if (cmd.set_ready)
                ready_reg <= 1'b1;

            if (cmd.scan_init)
            begin
                idx_reg    <= '0;
                pipe_v_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pipe_v_reg <= issue;
                if (issue)
                    idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.q_init)
            begin
                // start fresh: only the start node is marked
                visited_reg <= {{(rgr_pkg::MAX_NODES-1){1'b0}}, 1'b1} << src_reg;
                head_reg    <= '0;
                tail_reg    <= rgr_pkg::CNT_W'(1);
            end
            else
            begin
                if (push)
                begin
                    visited_reg[e_dst] <= 1'b1;
                    tail_reg           <= tail_reg + 1'b1;
                end
                if (cmd.pop)
                    head_reg <= head_reg + 1'b1;
            end

            done_reg <= cmd.res_en;
            if (cmd.res_en)
            begin
                status_reg <= (cmd.res_sel == rgr_pkg::RES_REJECT);
                reach_reg  <= (cmd.res_sel == rgr_pkg::RES_ONE);
                case (cmd.res_sel)
                    rgr_pkg::RES_NEW: index_reg <= total_reg[rgr_pkg::EDGE_AW-1:0];
                    rgr_pkg::RES_DUP: index_reg <= pipe_idx_reg;
                    default:          index_reg <= '0;
                endcase
            end
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign edge_index = index_reg;
    assign reachable  = reach_reg;

endmodule
`default_nettype wire

>>> rtl/relation_graph_reachability.sv
`default_nettype none
// Directed, relation-labelled edge table with breadth-first reachability.
// Pulse start while busy is low to issue a transaction; one result follows on
// done for a single cycle and cannot be held off. An add scans the stored
// edges one per cycle through the edge memory read port. A search query
// scans the whole edge table once per node taken from its queue, and stops
// early when an edge reaches the target node. nodes_in_use is written through
// cfg_write/cfg_data; the user must write it only while idle, since the block
// does not enforce this.
module relation_graph_reachability (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [rgr_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 mode,
    input  wire logic [rgr_pkg::NODE_W-1:0] source_node,
    input  wire logic [rgr_pkg::NODE_W-1:0] target_node,
    input  wire logic [rgr_pkg::REL_W-1:0]  relation_kind,
    output logic                            done,
    output logic                            status,
    output logic [rgr_pkg::EDGE_AW-1:0]     edge_index,
    output logic                            reachable
);

    rgr_pkg::cmd_t  cmd;
    rgr_pkg::stat_t stat;

    rgr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rgr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .source_node   (source_node),
        .target_node   (target_node),
        .relation_kind (relation_kind),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .edge_index    (edge_index),
        .reachable     (reachable)
    );

endmodule
`default_nettype wire

>>> rtl/rgr_checker.sv
`default_nettype none
module rgr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire logic                       status,
    input wire logic [rgr_pkg::EDGE_AW-1:0] edge_index,
    input wire logic                       reachable
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in flight");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> (edge_index == '0) && !reachable)
        else $error("rejected add carries an index or answer");

endmodule

bind relation_graph_reachability rgr_checker u_rgr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .edge_index (edge_index),
    .reachable  (reachable)
);
`default_nettype wire

>>> tb/tb_relation_graph_reachability.sv
`default_nettype none

class reach_scoreboard;
    typedef struct {
        logic       status;
        logic [9:0] edge_index;
        logic       reachable;
    } answer_t;

    logic [7:0] edge_src [rgr_pkg::MAX_EDGES];
    logic [7:0] edge_dst [rgr_pkg::MAX_EDGES];
    logic [7:0] edge_rel [rgr_pkg::MAX_EDGES];
    int         stored_edges;
    bit         table_ready;
    int         node_limit;
    answer_t    awaited [$];
    int         mismatches;
    int         checked;
    int         reach_hits;

    function new();
        stored_edges = 0;
        table_ready  = 0;
        node_limit   = 0;
        mismatches   = 0;
        checked      = 0;
        reach_hits   = 0;
    endfunction

    function bit bfs_reach(int from, int goal, logic [7:0] rel, int live);
        bit visited [256];
        int frontier [$];
        int node;
        foreach (visited[k]) visited[k] = 0;
        frontier.push_back(from);
        visited[from] = 1;
        while (frontier.size() > 0) begin
            node = frontier.pop_front();
            for (int i = 0; i < stored_edges; i++) begin
                if (edge_src[i] != node || edge_rel[i] != rel || edge_dst[i] >= live)
                    continue;
                if (edge_dst[i] == goal)
                    return 1;
                if (!visited[edge_dst[i]]) begin
                    visited[edge_dst[i]] = 1;
                    frontier.push_back(edge_dst[i]);
                end
            end
        end
        return 0;
    endfunction

    function void note_request(logic [1:0] md, logic [7:0] s, logic [7:0] t,
                               logic [7:0] r);
        answer_t a;
        int live;
        int hit;
        a.status     = 0;
        a.edge_index = '0;
        a.reachable  = 0;
        live = (node_limit > rgr_pkg::MAX_NODES) ? rgr_pkg::MAX_NODES : node_limit;
        if (md == rgr_pkg::MODE_ADD) begin
            if (s >= live || t >= live || r == 0 || stored_edges >= rgr_pkg::MAX_EDGES) begin
                a.status = 1;
            end else begin
                hit = -1;
                for (int i = 0; i < stored_edges; i++)
                    if (hit < 0 && edge_src[i] == s && edge_dst[i] == t && edge_rel[i] == r)
                        hit = i;
                if (hit >= 0) begin
                    a.edge_index = hit[9:0];
                end else begin
                    edge_src[stored_edges] = s;
                    edge_dst[stored_edges] = t;
                    edge_rel[stored_edges] = r;
                    a.edge_index = stored_edges[9:0];
                    stored_edges++;
                    table_ready = 0;
                end
            end
        end else if (md == rgr_pkg::MODE_REBUILD) begin
            table_ready = 1;
        end else if (md == rgr_pkg::MODE_QUERY) begin
            if (s < live && t < live && r != 0 && table_ready)
                a.reachable = (s == t) ? 1'b1 : bfs_reach(s, t, r, live);
        end
        awaited.push_back(a);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task check_answer(logic st, logic [9:0] idx, logic rch);
        answer_t a;
        if (awaited.size() == 0) begin
            report("result with no transaction outstanding");
            return;
        end
        a = awaited.pop_front();
        checked++;
        if (rch) reach_hits++;
        if (st !== a.status)
            report($sformatf("status %b, want %b", st, a.status));
        if (idx !== a.edge_index)
            report($sformatf("edge_index %0d, want %0d", idx, a.edge_index));
        if (rch !== a.reachable)
            report($sformatf("reachable %b, want %b", rch, a.reachable));
    endtask
endclass

module tb_relation_graph_reachability;
    timeunit 1ns;
    timeprecision 1ps;

    logic            clk;
    logic            rst_n;
    logic            cfg_write;
    logic [rgr_pkg::CNT_W-1:0] cfg_data;
    logic            start;
    logic            busy;
    logic [1:0]      mode;
    logic [7:0]      source_node;
    logic [7:0]      target_node;
    logic [7:0]      relation_kind;
    logic            done;
    logic            status;
    logic [9:0]      edge_index;
    logic            reachable;

    reach_scoreboard sb;
    int              idle_pct;
    int              issued;

    relation_graph_reachability dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .start(start), .busy(busy), .mode(mode), .source_node(source_node),
        .target_node(target_node), .relation_kind(relation_kind), .done(done),
        .status(status), .edge_index(edge_index), .reachable(reachable)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // sample mid-cycle, where outputs are settled
    always @(negedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(status, edge_index, reachable);
    end

    task issue(logic [1:0] md, logic [7:0] s, logic [7:0] t, logic [7:0] r);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            @(posedge clk);
        start         <= 1;
        mode          <= md;
        source_node   <= s;
        target_node   <= t;
        relation_kind <= r;
        forever
        begin
            @(negedge clk);
            if (!busy) break;
        end
        sb.note_request(md, s, t, r);
        issued++;
        @(posedge clk);
        start <= 0;
        @(posedge clk);
    endtask

    task set_nodes(int value);
        while (sb.awaited.size() != 0 || busy)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_write <= 1;
        cfg_data  <= value[rgr_pkg::CNT_W-1:0];
        @(posedge clk);
        cfg_write <= 0;
        sb.node_limit = value;
        @(posedge clk);
    endtask

    // mostly well-formed traffic over a few nodes and relations, some noise
    task random_item(int span);
        int pick;
        logic [7:0] rels [4];
        rels = '{8'd1, 8'd2, 8'd3, 8'd255};
        pick = $urandom_range(99);
        if (pick < 45)
            issue(rgr_pkg::MODE_ADD, 8'($urandom_range(span - 1)),
                  8'($urandom_range(span - 1)), rels[$urandom_range(3)]);
        else if (pick < 60)
            issue(rgr_pkg::MODE_REBUILD, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 92)
            issue(rgr_pkg::MODE_QUERY, 8'($urandom_range(span - 1)),
                  8'($urandom_range(span - 1)), rels[$urandom_range(3)]);
        else
            issue(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                  ($urandom_range(1) == 1) ? 8'd0 : 8'($urandom));
    endtask

    task random_phase(int nodes, int pct, int count);
        int span;
        set_nodes(nodes);
        idle_pct = pct;
        span = (nodes > 12) ? 12 : ((nodes < 1) ? 1 : nodes);
        repeat (count) random_item(span);
    endtask

    initial
    begin
        sb            = new();
        issued        = 0;
        idle_pct      = 0;
        rst_n         = 0;
        cfg_write     = 0;
        cfg_data      = '0;
        start         = 0;
        mode          = rgr_pkg::MODE_ADD;
        source_node   = '0;
        target_node   = '0;
        relation_kind = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: rejects, duplicates, ready flag, trivial and real searches
        set_nodes(8);
        issue(rgr_pkg::MODE_QUERY, 0, 1, 1);
        issue(rgr_pkg::MODE_ADD, 0, 1, 1);
        issue(rgr_pkg::MODE_ADD, 1, 2, 1);
        issue(rgr_pkg::MODE_ADD, 2, 3, 2);
        issue(rgr_pkg::MODE_ADD, 7, 0, 255);
        issue(rgr_pkg::MODE_ADD, 0, 1, 1);
        issue(rgr_pkg::MODE_ADD, 0, 1, 0);
        issue(rgr_pkg::MODE_ADD, 8, 1, 1);
        issue(rgr_pkg::MODE_ADD, 1, 255, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 2, 1);
        issue(rgr_pkg::MODE_REBUILD, 0, 0, 0);
        issue(rgr_pkg::MODE_QUERY, 0, 2, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 3, 1);
        issue(rgr_pkg::MODE_QUERY, 3, 3, 9);
        issue(rgr_pkg::MODE_QUERY, 7, 1, 255);
        issue(rgr_pkg::MODE_QUERY, 9, 1, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 2, 0);
        issue(2'd3, 255, 255, 255);
        issue(rgr_pkg::MODE_ADD, 0, 1, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 1, 1);
        issue(rgr_pkg::MODE_ADD, 3, 4, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 1, 1);
        issue(rgr_pkg::MODE_REBUILD, 255, 255, 255);
        // shrink: edges past the limit drop out of the search
        set_nodes(2);
        issue(rgr_pkg::MODE_QUERY, 0, 1, 1);
        issue(rgr_pkg::MODE_QUERY, 1, 0, 1);
        set_nodes(0);
        issue(rgr_pkg::MODE_ADD, 0, 0, 1);
        issue(rgr_pkg::MODE_QUERY, 0, 0, 1);

        random_phase(12, 0, 60);
        random_phase(16, 68, 60);
        random_phase(5, 19, 60);
        random_phase(511, 0, 50);
        random_phase(256, 68, 60);

        // fill the table, then hit it while full
        set_nodes(256);
        idle_pct = 0;
        while (sb.stored_edges < rgr_pkg::MAX_EDGES)
            issue(rgr_pkg::MODE_ADD, 8'($urandom), 8'($urandom),
                  8'($urandom_range(255, 1)));
        set_nodes(4);
        issue(rgr_pkg::MODE_ADD, 0, 1, 1);
        issue(rgr_pkg::MODE_ADD, 3, 3, 200);
        issue(rgr_pkg::MODE_REBUILD, 0, 0, 0);
        issue(rgr_pkg::MODE_QUERY, 0, 2, 1);
        issue(rgr_pkg::MODE_QUERY, 3, 0, 2);

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d transactions issued, %0d results checked, %0d reachable answers",
                 issued, sb.checked, sb.reach_hits);
        $display("edge table filled to %0d entries; %0d mismatches",
                 sb.stored_edges, sb.mismatches);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("timeout waiting on the block");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
